### src/psem_pkg.sv
package psem_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF     = 8;
   localparam int PRIO_BITS_DEF   = 8;

   localparam int FUNC_W    = 3;
   localparam int STAT_W    = 3;
   localparam int CFG_W     = 16;
   localparam int CNT_W     = 18;
   localparam int CNT_OUT_W = 17;

   localparam logic signed [CNT_W-1:0] COUNT_MAX = CNT_W'(65535);
   localparam logic signed [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   typedef enum logic [FUNC_W-1:0] {
      FN_ACQUIRE  = 3'd0,
      FN_RELEASE  = 3'd1,
      FN_TRY      = 3'd2,
      FN_CHG_PRIO = 3'd3,
      FN_ABORT    = 3'd4
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_SATURATED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      Q_INSERT,
      Q_POP_HEAD,
      Q_FIND_DEL,
      Q_REPRIO
   } qop_type;

   typedef enum logic [2:0] {
      QS_IDLE,
      QS_FIND,
      QS_HEAD_RD,
      QS_HEAD_CAP,
      QS_REMOVE,
      QS_INSERT,
      QS_DONE
   } qstate_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic    start;
      logic    clear;
      qop_type op;
   } qcmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } qrsp_type;

endpackage

### src/priority_wait_semaphore.sv
// Counting semaphore with a priority-sorted wait queue of QUEUE_DEPTH entries.
// One request is in work at a time. Acquire and try acquire that do not block,
// and a release that wakes nobody, leave the queue alone and go straight to the
// response. Anything touching the queue runs through a walker over a
// single-read, single-write entry RAM that moves one entry per cycle. An insert
// walks from the tail, a release with a waiter pops the head, an abort finds and
// deletes the thread, and a change of priority deletes it and inserts it anew.
// A response that is not taken holds the request in S_FINISH, so the next
// request waits. Writing csr_initial_count loads the count and empties the queue
// at once; the count resets to 1. Counts below zero equal minus the number of
// waiters.
module priority_wait_semaphore #(
   parameter int QUEUE_DEPTH = psem_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = psem_pkg::ID_BITS_DEF,
   parameter int PRIO_BITS   = psem_pkg::PRIO_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [psem_pkg::FUNC_W-1:0]            req_func,
   input  logic [ID_BITS-1:0]                     req_thread_id,
   input  logic [PRIO_BITS-1:0]                   req_priority_req,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_granted,
   output logic                                   rsp_blocked,
   output logic                                   rsp_woken_valid,
   output logic [ID_BITS-1:0]                     rsp_woken_thread,
   output logic [psem_pkg::STAT_W-1:0]            rsp_status,
   output logic signed [psem_pkg::CNT_OUT_W-1:0]  rsp_count_now,
   output logic                                   rsp_held,
   input  logic                                   csr_write_en,
   input  logic [psem_pkg::CFG_W-1:0]             csr_initial_count
);

   localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

   psem_pkg::state_type state_ff, state_in;

   logic signed [psem_pkg::CNT_W-1:0] count_ff, count_in;
   logic [psem_pkg::FUNC_W-1:0]       func_ff, func_in;
   logic                              granted_ff, granted_in;
   logic                              blocked_ff, blocked_in;
   logic                              wvalid_ff, wvalid_in;
   psem_pkg::status_type              status_ff, status_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_granted_ff, rsp_blocked_ff, rsp_wvalid_ff;
   logic [ID_BITS-1:0]                rsp_wthread_ff;
   psem_pkg::status_type              rsp_status_ff;
   logic signed [psem_pkg::CNT_OUT_W-1:0] rsp_count_ff;
   logic                              rsp_held_ff;
   logic                              rsp_load;

   psem_pkg::qcmd_type qcmd;
   psem_pkg::qrsp_type qrsp;
   logic [LEN_W-1:0]   q_len;
   logic [ID_BITS-1:0] q_head;

   psem_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS),
      .PRIO_BITS   (PRIO_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd      (qcmd),
      .cmd_id   (req_thread_id),
      .cmd_prio (req_priority_req),
      .rsp      (qrsp),
      .len      (q_len),
      .head_id  (q_head)
   );

   assign req_ready = (state_ff == psem_pkg::S_IDLE);
   assign rsp_load  = (state_ff == psem_pkg::S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psem_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = qcmd.start ? psem_pkg::S_WAIT : psem_pkg::S_FINISH;
            end
         end
         psem_pkg::S_WAIT: begin
            if (qrsp.done) begin
               state_in = psem_pkg::S_FINISH;
            end
         end
         psem_pkg::S_FINISH: begin
            if (rsp_load) begin
               state_in = psem_pkg::S_IDLE;
            end
         end
         default: state_in = psem_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      func_in    = func_ff;
      granted_in = granted_ff;
      blocked_in = blocked_ff;
      wvalid_in  = wvalid_ff;
      status_in  = status_ff;
      qcmd.start = 1'b0;
      qcmd.clear = csr_write_en;
      qcmd.op    = psem_pkg::Q_INSERT;
      unique case (state_ff)
         psem_pkg::S_IDLE: begin
            if (req_valid) begin
               func_in    = req_func;
               granted_in = 1'b0;
               blocked_in = 1'b0;
               wvalid_in  = 1'b0;
               status_in  = psem_pkg::ST_OK;
               unique case (req_func)
                  psem_pkg::FN_ACQUIRE: begin
                     if (count_ff > 0) begin
                        count_in   = count_ff - psem_pkg::CNT_ONE;
                        granted_in = 1'b1;
                     end else if (q_len >= LEN_W'(QUEUE_DEPTH)) begin
                        status_in = psem_pkg::ST_FULL;
                     end else begin
                        count_in   = count_ff - psem_pkg::CNT_ONE;
                        blocked_in = 1'b1;
                        qcmd.start = 1'b1;
                        qcmd.op    = psem_pkg::Q_INSERT;
                     end
                  end
                  psem_pkg::FN_RELEASE: begin
                     if (count_ff < 0) begin
                        if (q_len == '0) begin
                           status_in = psem_pkg::ST_EMPTY;
                        end else begin
                           count_in   = count_ff + psem_pkg::CNT_ONE;
                           wvalid_in  = 1'b1;
                           qcmd.start = 1'b1;
                           qcmd.op    = psem_pkg::Q_POP_HEAD;
                        end
                     end else if (count_ff >= psem_pkg::COUNT_MAX) begin
                        status_in = psem_pkg::ST_SATURATED;
                     end else begin
                        count_in = count_ff + psem_pkg::CNT_ONE;
                     end
                  end
                  psem_pkg::FN_TRY: begin
                     if (count_ff > 0) begin
                        count_in   = count_ff - psem_pkg::CNT_ONE;
                        granted_in = 1'b1;
                     end
                  end
                  psem_pkg::FN_CHG_PRIO: begin
                     qcmd.start = 1'b1;
                     qcmd.op    = psem_pkg::Q_REPRIO;
                  end
                  psem_pkg::FN_ABORT: begin
                     qcmd.start = 1'b1;
                     qcmd.op    = psem_pkg::Q_FIND_DEL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         psem_pkg::S_WAIT: begin
            if (qrsp.done && wvalid_ff == 1'b0 && blocked_ff == 1'b0) begin
               if (!qrsp.found) begin
                  status_in = psem_pkg::ST_NOT_FOUND;
               end else if (func_ff == psem_pkg::FN_ABORT) begin
                  if (count_ff >= psem_pkg::COUNT_MAX) begin
                     status_in = psem_pkg::ST_SATURATED;
                  end else begin
                     count_in = count_ff + psem_pkg::CNT_ONE;
                  end
               end
            end
         end
         psem_pkg::S_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psem_pkg::S_IDLE;
         count_ff     <= psem_pkg::CNT_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            count_ff <= psem_pkg::CNT_W'(csr_initial_count);
         end else begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      granted_ff <= granted_in;
      blocked_ff <= blocked_in;
      wvalid_ff  <= wvalid_in;
      status_ff  <= status_in;
      if (rsp_load) begin
         rsp_granted_ff <= granted_ff;
         rsp_blocked_ff <= blocked_ff;
         rsp_wvalid_ff  <= wvalid_ff;
         rsp_wthread_ff <= wvalid_ff ? q_head : '0;
         rsp_status_ff  <= status_ff;
         rsp_count_ff   <= count_ff[psem_pkg::CNT_OUT_W-1:0];
         rsp_held_ff    <= (count_ff <= 0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_blocked      = rsp_blocked_ff;
   assign rsp_woken_valid  = rsp_wvalid_ff;
   assign rsp_woken_thread = rsp_wthread_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count_now    = rsp_count_ff;
   assign rsp_held         = rsp_held_ff;

endmodule

### src/psem_queue.sv
module psem_queue #(
   parameter int QUEUE_DEPTH = psem_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = psem_pkg::ID_BITS_DEF,
   parameter int PRIO_BITS   = psem_pkg::PRIO_BITS_DEF,
   localparam int LEN_W      = $clog2(QUEUE_DEPTH + 1),
   localparam int IDX_W      = $clog2(QUEUE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  psem_pkg::qcmd_type   cmd,
   input  logic [ID_BITS-1:0]   cmd_id,
   input  logic [PRIO_BITS-1:0] cmd_prio,
   output psem_pkg::qrsp_type   rsp,
   output logic [LEN_W-1:0]     len,
   output logic [ID_BITS-1:0]   head_id
);

   localparam int ENT_W = ID_BITS + PRIO_BITS;

   // entries kept sorted, highest priority at index 0
   logic [ENT_W-1:0] mem [QUEUE_DEPTH];
   logic [ENT_W-1:0] rdata_ff;

   psem_pkg::qstate_type state_ff, state_in;
   psem_pkg::qop_type    op_ff, op_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     idx_ff, idx_in;
   logic                 look_ff, look_in;
   logic                 found_ff, found_in;
   logic [ID_BITS-1:0]   head_ff, head_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;

   logic                 rd_en;
   logic [LEN_W-1:0]     rd_idx;
   logic                 wr_en;
   logic [LEN_W-1:0]     wr_idx;
   logic [ENT_W-1:0]     wr_data;

   logic [ID_BITS-1:0]   rd_id;
   logic [PRIO_BITS-1:0] rd_prio;
   logic [ENT_W-1:0]     new_ent;
   logic                 at_end;
   logic                 id_hit;
   logic                 shift_up;

   assign rd_id    = rdata_ff[ENT_W-1:PRIO_BITS];
   assign rd_prio  = rdata_ff[PRIO_BITS-1:0];
   assign new_ent  = {id_ff, prio_ff};
   assign at_end   = (idx_ff >= len_ff);
   // rdata_ff holds entry idx_ff-1 whenever look_ff is set
   assign id_hit   = look_ff && (rd_id == id_ff);
   assign shift_up = (prio_ff > rd_prio);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_idx[IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psem_pkg::QS_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.op)
                  psem_pkg::Q_INSERT:   state_in = psem_pkg::QS_INSERT;
                  psem_pkg::Q_POP_HEAD: state_in = psem_pkg::QS_HEAD_RD;
                  psem_pkg::Q_FIND_DEL: state_in = psem_pkg::QS_FIND;
                  psem_pkg::Q_REPRIO:   state_in = psem_pkg::QS_FIND;
                  default:              state_in = psem_pkg::QS_IDLE;
               endcase
            end
         end
         psem_pkg::QS_FIND: begin
            if (id_hit) begin
               state_in = psem_pkg::QS_REMOVE;
            end else if (at_end) begin
               state_in = psem_pkg::QS_DONE;
            end
         end
         psem_pkg::QS_HEAD_RD:  state_in = psem_pkg::QS_HEAD_CAP;
         psem_pkg::QS_HEAD_CAP: state_in = psem_pkg::QS_REMOVE;
         psem_pkg::QS_REMOVE: begin
            if (at_end) begin
               state_in = (op_ff == psem_pkg::Q_REPRIO) ? psem_pkg::QS_INSERT
                                                         : psem_pkg::QS_DONE;
            end
         end
         psem_pkg::QS_INSERT: begin
            if ((!look_ff && idx_ff == '0) || (look_ff && !shift_up)) begin
               state_in = psem_pkg::QS_DONE;
            end
         end
         psem_pkg::QS_DONE: state_in = psem_pkg::QS_IDLE;
         default:           state_in = psem_pkg::QS_IDLE;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      look_in  = look_ff;
      len_in   = len_ff;
      found_in = found_ff;
      head_in  = head_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      op_in    = op_ff;
      rd_en    = 1'b0;
      rd_idx   = idx_ff;
      wr_en    = 1'b0;
      wr_idx   = idx_ff;
      wr_data  = rdata_ff;
      unique case (state_ff)
         psem_pkg::QS_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               id_in    = cmd_id;
               prio_in  = cmd_prio;
               found_in = 1'b0;
               look_in  = 1'b0;
               idx_in   = (cmd.op == psem_pkg::Q_INSERT) ? len_ff : '0;
            end
         end
         psem_pkg::QS_FIND: begin
            rd_en  = !at_end;
            rd_idx = idx_ff;
            if (id_hit) begin
               // idx_ff is already one past the match: start of the shift
               found_in = 1'b1;
               look_in  = 1'b0;
            end else if (!at_end) begin
               idx_in  = idx_ff + LEN_W'(1);
               look_in = 1'b1;
            end
         end
         psem_pkg::QS_HEAD_RD: begin
            rd_en  = 1'b1;
            rd_idx = '0;
         end
         psem_pkg::QS_HEAD_CAP: begin
            head_in = rd_id;
            idx_in  = LEN_W'(1);
            look_in = 1'b0;
         end
         psem_pkg::QS_REMOVE: begin
            // read entry i+1 while writing the previous read down to i-1
            if (look_ff) begin
               wr_en   = 1'b1;
               wr_idx  = idx_ff - LEN_W'(2);
               wr_data = rdata_ff;
            end
            if (!at_end) begin
               rd_en   = 1'b1;
               rd_idx  = idx_ff;
               idx_in  = idx_ff + LEN_W'(1);
               look_in = 1'b1;
            end else begin
               len_in  = len_ff - LEN_W'(1);
               idx_in  = len_ff - LEN_W'(1);
               look_in = 1'b0;
            end
         end
         psem_pkg::QS_INSERT: begin
            // walk from the tail, moving lower-priority entries up one slot
            if (!look_ff) begin
               if (idx_ff == '0) begin
                  wr_en   = 1'b1;
                  wr_idx  = '0;
                  wr_data = new_ent;
                  len_in  = len_ff + LEN_W'(1);
               end else begin
                  rd_en   = 1'b1;
                  rd_idx  = idx_ff - LEN_W'(1);
                  look_in = 1'b1;
               end
            end else if (shift_up) begin
               wr_en   = 1'b1;
               wr_idx  = idx_ff;
               wr_data = rdata_ff;
               if (idx_ff == LEN_W'(1)) begin
                  idx_in  = '0;
                  look_in = 1'b0;
               end else begin
                  rd_en  = 1'b1;
                  rd_idx = idx_ff - LEN_W'(2);
                  idx_in = idx_ff - LEN_W'(1);
               end
            end else begin
               wr_en   = 1'b1;
               wr_idx  = idx_ff;
               wr_data = new_ent;
               len_in  = len_ff + LEN_W'(1);
            end
         end
         psem_pkg::QS_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psem_pkg::QS_IDLE;
         len_ff   <= '0;
         look_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else if (cmd.clear) begin
         state_ff <= psem_pkg::QS_IDLE;
         len_ff   <= '0;
         look_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         look_ff  <= look_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      head_ff <= head_in;
      id_ff   <= id_in;
      prio_ff <= prio_in;
      op_ff   <= op_in;
   end

   assign rsp.done  = (state_ff == psem_pkg::QS_DONE);
   assign rsp.found = found_ff;
   assign len       = len_ff;
   assign head_id   = head_ff;

endmodule

### src/psem_checker.sv
module psem_checker #(
   parameter int ID_BITS = psem_pkg::ID_BITS_DEF
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_granted,
   input logic                                  rsp_blocked,
   input logic                                  rsp_woken_valid,
   input logic [ID_BITS-1:0]                    rsp_woken_thread,
   input logic [psem_pkg::STAT_W-1:0]           rsp_status,
   input logic signed [psem_pkg::CNT_OUT_W-1:0] rsp_count_now,
   input logic                                  rsp_held
);

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count_now)
         && $stable(rsp_status) && $stable(rsp_woken_thread))
      else $error("stalled response changed");

   // a blocked caller leaves the count negative and never also holds a grant
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blocked |-> rsp_held && !rsp_granted
         && rsp_status == psem_pkg::ST_OK && rsp_count_now < 0)
      else $error("blocked response inconsistent");

   // a woken waiter means the queue was in use, so the count cannot be positive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_woken_valid |-> rsp_held && rsp_status == psem_pkg::ST_OK)
      else $error("wake reported with positive count or fault");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_woken_valid |-> rsp_woken_thread == '0)
      else $error("woken thread reported without a wake");

endmodule

bind priority_wait_semaphore psem_checker #(
   .ID_BITS (ID_BITS)
) u_psem_checker (.*);
